FILE: src/gbw_pkg.sv
`default_nettype none

package gbw_pkg;

	localparam int WEIGHT_BITS = 16;
	localparam int FRAC_BITS = WEIGHT_BITS - 1;
	localparam int RECIP_BITS = 25;
	localparam int ROUND_SHIFT = FRAC_BITS + 24;
	localparam int ROW_BITS = 17;
	localparam int PIX_BITS = 8;
	localparam int DIST_BITS = 3;
	localparam int RADIUS_BITS = 2;
	localparam int FW_BITS = 11;
	localparam int FH_BITS = 16;
	localparam int CFG_DATA_BITS = 25;
	localparam int CFG_INDEX_BITS = 3;

	// register map of the configuration port
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_KERNEL_RADIUS,
		REG_WEIGHT_CENTER,
		REG_WEIGHT_OFF_ONE,
		REG_WEIGHT_OFF_TWO,
		REG_WEIGHT_OFF_THREE,
		REG_NORM_RECIPROCAL,
		REG_FRAME_WIDTH,
		REG_FRAME_HEIGHT
	} reg_index_t;

	typedef struct packed {
		logic [RADIUS_BITS-1:0] kernel_radius;
		logic [WEIGHT_BITS-1:0] weight_center;
		logic [WEIGHT_BITS-1:0] weight_off_one;
		logic [WEIGHT_BITS-1:0] weight_off_two;
		logic [WEIGHT_BITS-1:0] weight_off_three;
		logic [RECIP_BITS-1:0]  norm_reciprocal;
		logic [FW_BITS-1:0]     frame_width;
		logic [FH_BITS-1:0]     frame_height;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic locate;
		logic commit;
		logic rd;
		logic center;
		logic acc;
		logic scale;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic valid;
		logic interior;
		logic col_end;
		logic row_end;
	} status_t;

	// one-dimensional weight at a given distance from the center
	function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [DIST_BITS-1:0] d,
			input cfg_t c);
		logic [WEIGHT_BITS-1:0] wt;
		case (d)
			DIST_BITS'(0): wt = c.weight_center;
			DIST_BITS'(1): wt = c.weight_off_one;
			DIST_BITS'(2): wt = c.weight_off_two;
			DIST_BITS'(3): wt = c.weight_off_three;
			default: wt = '0;
		endcase
		return wt;
	endfunction

endpackage

`default_nettype wire

FILE: src/gbw_cfg.sv
`default_nettype none

module gbw_cfg import gbw_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// register file, each write masked to the register width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_radius <= RADIUS_BITS'(1);
			cfg_q.weight_center <= WEIGHT_BITS'(32768);
			cfg_q.weight_off_one <= '0;
			cfg_q.weight_off_two <= '0;
			cfg_q.weight_off_three <= '0;
			cfg_q.norm_reciprocal <= RECIP_BITS'(16777216);
			cfg_q.frame_width <= FW_BITS'(640);
			cfg_q.frame_height <= FH_BITS'(480);
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_KERNEL_RADIUS:    cfg_q.kernel_radius <= cfg_data[RADIUS_BITS-1:0];
				REG_WEIGHT_CENTER:    cfg_q.weight_center <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_OFF_ONE:   cfg_q.weight_off_one <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_OFF_TWO:   cfg_q.weight_off_two <= cfg_data[WEIGHT_BITS-1:0];
				REG_WEIGHT_OFF_THREE: cfg_q.weight_off_three <= cfg_data[WEIGHT_BITS-1:0];
				REG_NORM_RECIPROCAL:  cfg_q.norm_reciprocal <= cfg_data[RECIP_BITS-1:0];
				REG_FRAME_WIDTH:      cfg_q.frame_width <= cfg_data[FW_BITS-1:0];
				REG_FRAME_HEIGHT:     cfg_q.frame_height <= cfg_data[FH_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: src/gbw_ctrl.sv
`default_nettype none

module gbw_ctrl import gbw_pkg::*; #(
	parameter int TAP_BITS = 3
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pixel_valid,
	output logic                pixel_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  status_t             status,
	output cmd_t                cmd,
	output logic [TAP_BITS-1:0] tap_i,
	output logic [TAP_BITS-1:0] tap_j
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOCATE,
		ST_COMMIT,
		ST_TAPS,
		ST_PASS,
		ST_DRAIN,
		ST_SETTLE,
		ST_SCALE,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic [TAP_BITS-1:0] tap_i_q;
	logic [TAP_BITS-1:0] tap_j_q;
	logic result_valid_q;
	logic out_free;

	// output register free to take the next result
	assign out_free = !result_valid_q || result_ready;

	// sequencer, window counters and result flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_i_q <= '0;
			tap_j_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			// result flag: set by a finished request, cleared when taken
			if (state_q == ST_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pixel_valid) begin
						state_q <= ST_LOCATE;
					end
				end
				ST_LOCATE: state_q <= ST_COMMIT;
				ST_COMMIT: begin
					tap_i_q <= '0;
					tap_j_q <= '0;
					if (!status.valid) begin
						state_q <= ST_FINISH;
					end else if (status.interior) begin
						state_q <= ST_TAPS;
					end else begin
						state_q <= ST_PASS;
					end
				end
				ST_TAPS: begin
					if (status.col_end) begin
						tap_j_q <= '0;
						if (status.row_end) begin
							state_q <= ST_DRAIN;
						end else begin
							tap_i_q <= tap_i_q + 1'b1;
						end
					end else begin
						tap_j_q <= tap_j_q + 1'b1;
					end
				end
				ST_PASS:   state_q <= ST_FINISH;
				ST_DRAIN:  state_q <= ST_SETTLE;
				ST_SETTLE: state_q <= ST_SCALE;
				ST_SCALE:  state_q <= ST_FINISH;
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// commands decoded from the state
	always_comb begin
		cmd = '0;
		cmd.capture = (state_q == ST_IDLE) && pixel_valid;
		cmd.locate = (state_q == ST_LOCATE);
		cmd.commit = (state_q == ST_COMMIT);
		cmd.rd = (state_q == ST_TAPS) || (state_q == ST_PASS);
		cmd.center = (state_q == ST_PASS);
		cmd.acc = (state_q == ST_TAPS);
		cmd.scale = (state_q == ST_SCALE);
		cmd.out_load = (state_q == ST_FINISH) && out_free;
	end

	assign pixel_ready = (state_q == ST_IDLE);
	assign result_valid = result_valid_q;
	assign tap_i = tap_i_q;
	assign tap_j = tap_j_q;

endmodule

`default_nettype wire

FILE: src/gbw_datapath.sv
`default_nettype none

module gbw_datapath import gbw_pkg::*; #(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH = 1024,
	parameter int TAP_BITS = $clog2(2 * MAX_RADIUS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  cmd_t                cmd,
	input  logic [TAP_BITS-1:0] tap_i,
	input  logic [TAP_BITS-1:0] tap_j,
	input  logic [PIX_BITS-1:0] pixel_in,
	output status_t             status,
	output logic [PIX_BITS-1:0] pixel_out,
	output logic                out_valid,
	output logic                out_last
);

	localparam int RING = 2 * MAX_RADIUS + 1;
	localparam int RB = $clog2(RING);
	localparam int TB = RB + 1;
	localparam int YW = $clog2(3 * RING);
	localparam int KW = $clog2(MAX_RADIUS + 1);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int XW = CW + 1;
	localparam int EW = XW + 1;
	localparam int DEPTH = RING * MAX_WIDTH;
	localparam int AW = $clog2(DEPTH);
	localparam int PW = ROW_BITS + WW + 1;
	localparam int QW = ROW_BITS + 1;
	localparam int WPW = 2 * WEIGHT_BITS;
	localparam int HWB = WPW + 1 - FRAC_BITS;
	localparam int TERMW = HWB + PIX_BITS;
	localparam int ACCW = TERMW + $clog2(RING * RING);
	localparam int PRODW = ACCW + RECIP_BITS;
	localparam int RESW = PRODW + 1 - ROUND_SHIFT;

	// effective radius, width and height
	logic [KW-1:0] k;
	logic [WW-1:0] w;
	logic [FH_BITS-1:0] h;

	always_comb begin
		if (cfg.kernel_radius > MAX_RADIUS) begin
			k = KW'(MAX_RADIUS);
		end else begin
			k = KW'(cfg.kernel_radius);
		end
		if (cfg.frame_width == '0) begin
			w = WW'(1);
		end else if (cfg.frame_width > MAX_WIDTH) begin
			w = WW'(MAX_WIDTH);
		end else begin
			w = WW'(cfg.frame_width);
		end
		if (cfg.frame_height == '0) begin
			h = FH_BITS'(1);
		end else begin
			h = cfg.frame_height;
		end
	end

	// input position and its line store row
	logic [CW-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [RB-1:0] ring_q;
	logic [PIX_BITS-1:0] pix_q;

	// located request
	logic [PW-1:0] p_q;
	logic [PW-1:0] lag_q;
	logic [PW-1:0] fpx_q;
	logic [QW-1:0] qr_q;
	logic [CW-1:0] qc_q;
	logic [RB-1:0] top_q;

	logic [XW-1:0] col_inc;
	logic [RB-1:0] ring_inc;
	logic in_frame;
	logic frame_end;

	assign col_inc = XW'(col_q) + XW'(1);
	assign ring_inc = (ring_q == RB'(RING - 1)) ? '0 : ring_q + 1'b1;
	assign in_frame = p_q < fpx_q;
	assign frame_end = (p_q + PW'(1)) >= (fpx_q + lag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ring_q <= '0;
		end else if (cmd.capture) begin
			// column left past a narrowed width wraps to the next row
			if (XW'(col_q) >= XW'(w)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
				ring_q <= ring_inc;
			end
		end else if (cmd.commit) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
				ring_q <= '0;
			end else if (col_inc >= XW'(w)) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
				ring_q <= ring_inc;
			end else begin
				col_q <= CW'(col_inc);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pix_q <= pixel_in;
		end
	end

	// output position lags by k rows and k pixels; a row narrower than k
	// makes the lag reach back over up to three row starts
	logic [1:0] borrow;
	logic [EW-1:0] cb1;
	logic [EW-1:0] cb2;
	logic [EW-1:0] cb3;
	logic [EW-1:0] qc_raw;
	logic [YW-1:0] top_raw;
	logic [YW-1:0] top_red;

	assign cb1 = EW'(col_q) + EW'(w);
	assign cb2 = cb1 + EW'(w);
	assign cb3 = cb2 + EW'(w);

	always_comb begin
		if (EW'(col_q) >= EW'(k)) begin
			borrow = 2'd0;
			qc_raw = EW'(col_q) - EW'(k);
		end else if (cb1 >= EW'(k)) begin
			borrow = 2'd1;
			qc_raw = cb1 - EW'(k);
		end else if (cb2 >= EW'(k)) begin
			borrow = 2'd2;
			qc_raw = cb2 - EW'(k);
		end else begin
			borrow = 2'd3;
			qc_raw = cb3 - EW'(k);
		end
	end

	assign top_raw = YW'(ring_q) + YW'(2 * RING) - YW'({k, 1'b0}) - YW'(borrow);
	assign top_red = (top_raw >= YW'(2 * RING)) ? (top_raw - YW'(2 * RING))
		: ((top_raw >= YW'(RING)) ? (top_raw - YW'(RING)) : top_raw);

	always_ff @(posedge clk) begin
		if (cmd.locate) begin
			p_q <= PW'(row_q) * PW'(w) + PW'(col_q);
			lag_q <= PW'(k) * PW'(w) + PW'(k);
			fpx_q <= PW'(w) * PW'(h);
			qr_q <= QW'(row_q) - QW'(k) - QW'(borrow);
			qc_q <= CW'(qc_raw);
			top_q <= RB'(top_red);
		end
	end

	// classification of the output position
	logic [ROW_BITS-1:0] qr_u;
	logic q_valid;
	logic q_interior;
	logic q_last;
	logic valid_q;
	logic interior_q;
	logic last_q;

	assign qr_u = qr_q[ROW_BITS-1:0];
	assign q_valid = !qr_q[ROW_BITS] && (qr_u < ROW_BITS'(h));
	assign q_interior = q_valid && (qr_u >= ROW_BITS'(k))
		&& ((QW'(qr_u) + QW'(k)) < QW'(h))
		&& (XW'(qc_q) >= XW'(k))
		&& ((XW'(qc_q) + XW'(k)) < XW'(w));
	assign q_last = q_valid && (qr_u == ROW_BITS'(h) - ROW_BITS'(1))
		&& (XW'(qc_q) == XW'(w) - XW'(1));

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			valid_q <= q_valid;
			interior_q <= q_interior;
			last_q <= q_last;
		end
	end

	// window tap addressing
	logic [TAP_BITS-1:0] ti;
	logic [TAP_BITS-1:0] tj;
	logic [TAP_BITS-1:0] di;
	logic [TAP_BITS-1:0] dj;
	logic [TB-1:0] trow_raw;
	logic [RB-1:0] trow;
	logic [XW-1:0] tcol_raw;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;

	assign ti = cmd.center ? TAP_BITS'(k) : tap_i;
	assign tj = cmd.center ? TAP_BITS'(k) : tap_j;
	assign di = (ti >= TAP_BITS'(k)) ? (ti - TAP_BITS'(k)) : (TAP_BITS'(k) - ti);
	assign dj = (tj >= TAP_BITS'(k)) ? (tj - TAP_BITS'(k)) : (TAP_BITS'(k) - tj);
	assign trow_raw = TB'(top_q) + TB'(ti);
	assign trow = (trow_raw >= TB'(RING)) ? RB'(trow_raw - TB'(RING)) : RB'(trow_raw);
	assign tcol_raw = XW'(qc_q) + XW'(tj) - XW'(k);
	assign rd_addr = AW'(trow) * AW'(MAX_WIDTH) + AW'(CW'(tcol_raw));
	assign wr_addr = AW'(ring_q) * AW'(MAX_WIDTH) + AW'(col_q);

	// line store, one write or one read a cycle
	logic [PIX_BITS-1:0] line_mem [DEPTH];
	logic [PIX_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && in_frame) begin
			line_mem[wr_addr] <= pix_q;
		end
		if (cmd.rd) begin
			rdata_q <= line_mem[rd_addr];
		end
	end

	// tap pipeline: weight product, weighted pixel, accumulate
	logic [WPW-1:0] wprod_s1;
	logic [WPW:0] wrnd;
	logic [HWB-1:0] hw;
	logic [TERMW-1:0] term_s2;
	logic [ACCW-1:0] acc_q;
	logic [PRODW-1:0] prod_q;
	logic tap_s1;
	logic tap_s2;

	assign wrnd = (WPW + 1)'(wprod_s1) + ((WPW + 1)'(1) << (FRAC_BITS - 1));
	assign hw = HWB'(wrnd >> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_s1 <= 1'b0;
			tap_s2 <= 1'b0;
		end else begin
			tap_s1 <= cmd.acc;
			tap_s2 <= tap_s1;
		end
	end

	always_ff @(posedge clk) begin
		wprod_s1 <= WPW'(tap_weight(DIST_BITS'(di), cfg)) * WPW'(tap_weight(DIST_BITS'(dj), cfg));
		term_s2 <= TERMW'(hw) * TERMW'(rdata_q);
		if (cmd.commit) begin
			acc_q <= '0;
		end else if (tap_s2) begin
			acc_q <= acc_q + ACCW'(term_s2);
		end
		if (cmd.scale) begin
			prod_q <= PRODW'(acc_q) * PRODW'(cfg.norm_reciprocal);
		end
	end

	// normalize, round half up, saturate
	logic [PRODW:0] rsum;
	logic [RESW-1:0] res;
	logic [PIX_BITS-1:0] sat;

	assign rsum = (PRODW + 1)'(prod_q) + ((PRODW + 1)'(1) << (ROUND_SHIFT - 1));
	assign res = RESW'(rsum >> ROUND_SHIFT);
	assign sat = (res > RESW'(255)) ? PIX_BITS'(255) : PIX_BITS'(res);

	// result register
	logic [PIX_BITS-1:0] pixel_out_q;
	logic out_valid_q;
	logic out_last_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (!valid_q) begin
				pixel_out_q <= '0;
			end else if (interior_q) begin
				pixel_out_q <= sat;
			end else begin
				pixel_out_q <= rdata_q;
			end
			out_valid_q <= valid_q;
			out_last_q <= valid_q && last_q;
		end
	end

	assign pixel_out = pixel_out_q;
	assign out_valid = out_valid_q;
	assign out_last = out_last_q;

	// status for the sequencer
	always_comb begin
		status = '0;
		status.valid = q_valid;
		status.interior = q_interior;
		status.col_end = (tap_j == TAP_BITS'({k, 1'b0}));
		status.row_end = (tap_i == TAP_BITS'({k, 1'b0}));
	end

endmodule

`default_nettype wire

FILE: src/gaussian_blur_window_filter.sv
// Streaming Gaussian blur for 8-bit gray frames in raster order. Every accepted
// pixel request returns one result request; the result describes the pixel k rows
// plus k pixels behind the input, so a frame is flushed with k*width+k padding
// requests (out_valid is 0 while the pipe is still filling). Interior pixels get
// the separable (2k+1)x(2k+1) weighted sum times norm_reciprocal, rounded half up
// and saturated; pixels within k of an edge pass through. One request is worked
// at a time; an interior pixel is worked by the single multiply-accumulate that
// reads the line store one window tap per cycle, and a result still held by the
// sink holds back the next accept until it is taken. The next pixel is taken
// while a finished result waits in the output register. The line store is not
// cleared after reset; configuration is to be written by the user only between
// requests while the block is idle, which the block itself does not enforce.
`default_nettype none

module gaussian_blur_window_filter import gbw_pkg::*; #(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_write,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      pixel_valid,
	output logic                      pixel_ready,
	input  logic [PIX_BITS-1:0]       pixel_in,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [PIX_BITS-1:0]       pixel_out,
	output logic                      out_valid,
	output logic                      out_last
);

	localparam int TAP_BITS = $clog2(2 * MAX_RADIUS + 1);

	cfg_t cfg;
	cmd_t cmd;
	status_t status;
	logic [TAP_BITS-1:0] tap_i;
	logic [TAP_BITS-1:0] tap_j;

	// configuration registers
	gbw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	gbw_ctrl #(
		.TAP_BITS (TAP_BITS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd),
		.tap_i        (tap_i),
		.tap_j        (tap_j)
	);

	// line store, position tracking and arithmetic
	gbw_datapath #(
		.MAX_RADIUS (MAX_RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.TAP_BITS   (TAP_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.tap_i     (tap_i),
		.tap_j     (tap_j),
		.pixel_in  (pixel_in),
		.status    (status),
		.pixel_out (pixel_out),
		.out_valid (out_valid),
		.out_last  (out_last)
	);

endmodule

`default_nettype wire

FILE: src/gbw_checker.sv
`default_nettype none

module gbw_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       pixel_valid,
	input wire       pixel_ready,
	input wire       result_valid,
	input wire       result_ready,
	input wire [7:0] pixel_out,
	input wire       out_valid,
	input wire       out_last
);

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(pixel_out)
			&& $stable(out_valid) && $stable(out_last))
		else $error("result changed while stalled");

	// fill results carry a zero pixel and no frame end
	a_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !out_valid |-> pixel_out == 8'd0 && !out_last)
		else $error("fill result not zero");

	// frame end only on a real pixel
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && out_last |-> out_valid)
		else $error("frame end on a fill result");

	// one pixel request in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_ready |=> !pixel_ready)
		else $error("pixel taken while busy");

endmodule

bind gaussian_blur_window_filter gbw_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pixel_valid  (pixel_valid),
	.pixel_ready  (pixel_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.pixel_out    (pixel_out),
	.out_valid    (out_valid),
	.out_last     (out_last)
);

`default_nettype wire

FILE: test/testbench.sv
module testbench;
	import gbw_pkg::*;

	localparam int RING_ROWS = 7;
	localparam int MAX_LINE = 1024;
	localparam int SETTLE_CYCLES = 64;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_PIXELS = 450;

	typedef struct packed {
		logic [PIX_BITS-1:0] pixel;
		logic                valid;
		logic                last;
	} blur_result_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_KERNEL_RADIUS;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
	logic                      pixel_valid = 1'b0;
	logic                      pixel_ready;
	logic [PIX_BITS-1:0]       pixel_in = '0;
	logic                      result_valid;
	logic                      result_ready = 1'b0;
	logic [PIX_BITS-1:0]       pixel_out;
	logic                      out_valid;
	logic                      out_last;

	// expected blur results and the shadow state that predicts them
	blur_result_t        pending_pixels[$];
	blur_result_t        oldest;
	cfg_t                blur_cfg;
	logic [PIX_BITS-1:0] row_ring [0:RING_ROWS-1][0:MAX_LINE-1];
	int unsigned         feed_col = 0;
	int unsigned         feed_row = 0;

	bit          idle_on = 1'b1;
	int unsigned sink_stall = 0;
	int          fail_count = 0;
	int unsigned cycle_count = 0;

	gaussian_blur_window_filter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_in     (pixel_in),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.pixel_out    (pixel_out),
		.out_valid    (out_valid),
		.out_last     (out_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side back-pressure in random bursts
	always @(negedge clk) begin
		if (!idle_on) begin
			result_ready <= 1'b1;
		end else if (sink_stall != 0) begin
			result_ready <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if ($urandom_range(0, 9) == 0) begin
			result_ready <= 1'b0;
			sink_stall <= $urandom_range(0, 11);
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	// compare each result request with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
					$time, pixel_out, out_valid, out_last);
				fail_count++;
			end else begin
				oldest = pending_pixels.pop_front();
				compare_field("pixel_out", oldest.pixel, pixel_out);
				compare_field("out_valid", oldest.valid, out_valid);
				compare_field("out_last", oldest.last, out_last);
			end
		end
	end

	function automatic int unsigned active_width();
		if (blur_cfg.frame_width == 0)
			return 1;
		if (blur_cfg.frame_width > MAX_LINE)
			return MAX_LINE;
		return blur_cfg.frame_width;
	endfunction

	function automatic int unsigned active_height();
		return (blur_cfg.frame_height == 0) ? 1 : blur_cfg.frame_height;
	endfunction

	// requests needed for one full frame including the drain padding
	function automatic int unsigned frame_length();
		int unsigned w;
		w = active_width();
		return w * active_height() + blur_cfg.kernel_radius * w + blur_cfg.kernel_radius;
	endfunction

	// one pixel in, one result out: store, locate the delayed pixel, filter or pass
	function automatic blur_result_t blur_next_pixel(input logic [PIX_BITS-1:0] px);
		int unsigned     k, w, h, frame_px, lag, p, q, qr, qc, i, j, di, dj;
		longint unsigned taps [0:3];
		longint unsigned acc, weight_2d, scaled;
		blur_result_t    r;
		k = blur_cfg.kernel_radius;
		w = active_width();
		h = active_height();
		taps[0] = blur_cfg.weight_center;
		taps[1] = blur_cfg.weight_off_one;
		taps[2] = blur_cfg.weight_off_two;
		taps[3] = blur_cfg.weight_off_three;
		frame_px = w * h;
		lag = k * w + k;
		r = '0;
		// column left over from a wider setting moves to the next row
		if (feed_col >= w) begin
			feed_col = 0;
			feed_row++;
		end
		p = feed_row * w + feed_col;
		if (p < frame_px)
			row_ring[feed_row % RING_ROWS][feed_col] = px;
		if (p >= lag && p - lag < frame_px) begin
			q = p - lag;
			qr = q / w;
			qc = q % w;
			r.valid = 1'b1;
			r.last = (q == frame_px - 1);
			if (qr >= k && qr + k < h && qc >= k && qc + k < w) begin
				acc = 0;
				for (i = 0; i <= 2 * k; i++) begin
					for (j = 0; j <= 2 * k; j++) begin
						di = (i >= k) ? i - k : k - i;
						dj = (j >= k) ? j - k : k - j;
						weight_2d = (taps[di] * taps[dj] + (64'd1 << (FRAC_BITS - 1)))
							>> FRAC_BITS;
						acc += weight_2d * row_ring[(qr + i - k) % RING_ROWS][qc + j - k];
					end
				end
				scaled = (acc * blur_cfg.norm_reciprocal + (64'd1 << (ROUND_SHIFT - 1)))
					>> ROUND_SHIFT;
				r.pixel = (scaled > 255) ? 8'd255 : scaled[7:0];
			end else begin
				r.pixel = row_ring[qr % RING_ROWS][qc];
			end
		end
		// end of frame plus padding restarts the position
		if (p + 1 >= frame_px + lag) begin
			feed_col = 0;
			feed_row = 0;
		end else begin
			feed_col++;
			if (feed_col >= w) begin
				feed_col = 0;
				feed_row++;
			end
		end
		return r;
	endfunction

	// reciprocal that gives the 2-d kernel a gain of one
	function automatic int unsigned unit_gain_recip(input int unsigned radius,
			input int unsigned wc, input int unsigned w1, input int unsigned w2,
			input int unsigned w3);
		longint unsigned taps [0:3];
		longint unsigned total;
		int unsigned     i, j, di, dj;
		taps[0] = wc;
		taps[1] = w1;
		taps[2] = w2;
		taps[3] = w3;
		total = 0;
		for (i = 0; i <= 2 * radius; i++) begin
			for (j = 0; j <= 2 * radius; j++) begin
				di = (i >= radius) ? i - radius : radius - i;
				dj = (j >= radius) ? j - radius : radius - j;
				total += (taps[di] * taps[dj] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			end
		end
		if (total == 0)
			return 1 << 24;
		total = (64'd1 << ROUND_SHIFT) / total;
		return (total > 64'h1FFFFFF) ? 32'h1FFFFFF : total[31:0];
	endfunction

	task automatic write_reg(input reg_index_t idx, input int unsigned value);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_BITS'(value);
		case (idx)
			REG_KERNEL_RADIUS:    blur_cfg.kernel_radius = RADIUS_BITS'(value);
			REG_WEIGHT_CENTER:    blur_cfg.weight_center = WEIGHT_BITS'(value);
			REG_WEIGHT_OFF_ONE:   blur_cfg.weight_off_one = WEIGHT_BITS'(value);
			REG_WEIGHT_OFF_TWO:   blur_cfg.weight_off_two = WEIGHT_BITS'(value);
			REG_WEIGHT_OFF_THREE: blur_cfg.weight_off_three = WEIGHT_BITS'(value);
			REG_NORM_RECIPROCAL:  blur_cfg.norm_reciprocal = RECIP_BITS'(value);
			REG_FRAME_WIDTH:      blur_cfg.frame_width = FW_BITS'(value);
			REG_FRAME_HEIGHT:     blur_cfg.frame_height = FH_BITS'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic configure_frame(input int unsigned radius, input int unsigned wc,
			input int unsigned w1, input int unsigned w2, input int unsigned w3,
			input int unsigned recip, input int unsigned width, input int unsigned height);
		write_reg(REG_KERNEL_RADIUS, radius);
		write_reg(REG_WEIGHT_CENTER, wc);
		write_reg(REG_WEIGHT_OFF_ONE, w1);
		write_reg(REG_WEIGHT_OFF_TWO, w2);
		write_reg(REG_WEIGHT_OFF_THREE, w3);
		write_reg(REG_NORM_RECIPROCAL, recip);
		write_reg(REG_FRAME_WIDTH, width);
		write_reg(REG_FRAME_HEIGHT, height);
	endtask

	// one pixel request, with an optional gap in front
	task automatic send_pixel(input logic [PIX_BITS-1:0] px);
		if (idle_on && $urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 12)) @(negedge clk);
		pixel_valid = 1'b1;
		pixel_in = px;
		do
			@(posedge clk);
		while (!pixel_ready);
		pending_pixels.push_back(blur_next_pixel(px));
		@(negedge clk);
		pixel_valid = 1'b0;
	endtask

	task automatic wait_results_drained();
		while (pending_pixels.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// random pixels, optionally holding off until everything has come back
	task automatic send_frame(input int count, input int pause_at);
		int n;
		for (n = 0; n < count; n++) begin
			if (n == pause_at)
				wait_results_drained();
			send_pixel($urandom_range(0, 255));
		end
	endtask

	// leave a frame half done: a 1x1 setting puts the position past the end
	task automatic abort_frame();
		wait_results_drained();
		write_reg(REG_KERNEL_RADIUS, 0);
		write_reg(REG_FRAME_WIDTH, 1);
		write_reg(REG_FRAME_HEIGHT, 1);
		send_pixel($urandom_range(0, 255));
		wait_results_drained();
	endtask

	// degenerate sizes, saturation, a 3x3 interior pixel, a frame with no interior
	task automatic test_tiny_frames();
		int n;
		// zero width and height act as one; weight above one saturates
		configure_frame(0, 16'hFFFF, 0, 0, 0, 25'h1FFFFFF, 0, 0);
		send_pixel(8'd255);
		send_pixel(8'd0);
		wait_results_drained();
		// 3x3 frame, one interior pixel, pause mid-frame until all results are back
		configure_frame(1, 32768, 16384, 0, 0, 1 << 22, 3, 3);
		for (n = 0; n < 13; n++) begin
			if (n == 5)
				wait_results_drained();
			send_pixel((n % 2 == 0) ? 8'd255 : 8'd0);
		end
		wait_results_drained();
		// radius larger than the frame, everything passes through
		configure_frame(2, 32768, 20000, 9000, 3000, 0, 2, 2);
		send_frame(frame_length(), -1);
		wait_results_drained();
	endtask

	// radius zero so every window is the pixel just written
	task automatic test_mid_frame_changes();
		configure_frame(0, $urandom_range(0, 32768), 0, 0, 0,
			$urandom_range(0, 25'h1FFFFFF), 4, 16'hFFFF);
		send_frame(10, -1);
		wait_results_drained();
		// narrower row while the column is beyond it
		write_reg(REG_FRAME_WIDTH, 2);
		send_frame(5, -1);
		wait_results_drained();
		// shorter frame while the position is already beyond it
		write_reg(REG_FRAME_HEIGHT, 1);
		send_frame(1, -1);
		wait_results_drained();
	endtask

	task automatic test_widest_rows();
		// width above the line store size acts as the maximum
		configure_frame(0, 32768, 0, 0, 0, 1 << 24, 11'h7FF, 1);
		send_frame(frame_length(), -1);
		wait_results_drained();
		// largest radius and width: only the filling part of the pipe
		configure_frame(3, 32768, 24000, 13000, 5000,
			unit_gain_recip(3, 32768, 24000, 13000, 5000), 1024, 16'hFFFF);
		send_frame(60, -1);
		abort_frame();
	endtask

	task automatic test_random_frames();
		int unsigned radius, wc, w1, w2, w3, recip, fw, fh;
		int          length, sent, pause_at, sent_total;
		bit          broken;
		sent_total = 0;
		while (sent_total < RANDOM_PIXELS) begin
			radius = $urandom_range(0, 3);
			case ($urandom_range(0, 3))
				0: begin
					wc = $urandom_range(0, 32768);
					w1 = $urandom_range(0, 32768);
					w2 = $urandom_range(0, 32768);
					w3 = $urandom_range(0, 32768);
				end
				1: begin
					wc = $urandom_range(0, 16'hFFFF);
					w1 = $urandom_range(0, 16'hFFFF);
					w2 = $urandom_range(0, 16'hFFFF);
					w3 = $urandom_range(0, 16'hFFFF);
				end
				default: begin
					wc = $urandom_range(8000, 32768);
					w1 = wc * $urandom_range(20, 95) / 100;
					w2 = w1 * $urandom_range(20, 95) / 100;
					w3 = w2 * $urandom_range(20, 95) / 100;
				end
			endcase
			case ($urandom_range(0, 5))
				0: recip = 0;
				1: recip = $urandom_range(0, 25'h1FFFFFF);
				2: recip = 25'h1FFFFFF;
				default: recip = unit_gain_recip(radius, wc, w1, w2, w3);
			endcase
			case ($urandom_range(0, 9))
				0: fw = 0;
				1: fw = 2 * radius + 1;
				default: fw = $urandom_range(1, 12);
			endcase
			case ($urandom_range(0, 9))
				0: fh = 0;
				1: fh = 2 * radius + 1;
				default: fh = $urandom_range(1, 9);
			endcase
			configure_frame(radius, wc, w1, w2, w3, recip, fw, fh);
			idle_on = ($urandom_range(0, 3) != 0);
			length = frame_length();
			broken = ($urandom_range(0, 7) == 0);
			sent = broken ? $urandom_range(1, length) : length;
			pause_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, sent - 1) : -1;
			send_frame(sent, pause_at);
			wait_results_drained();
			if (broken)
				abort_frame();
			sent_total += sent;
		end
	endtask

	// back-to-back frames with no idling on either side
	task automatic test_steady_stream();
		idle_on = 1'b0;
		configure_frame(3, 30000, 22000, 12000, 5000,
			unit_gain_recip(3, 30000, 22000, 12000, 5000), 9, 8);
		send_frame(frame_length(), -1);
		wait_results_drained();
		configure_frame(1, 32768, 16000, 0, 0, unit_gain_recip(1, 32768, 16000, 0, 0), 12, 10);
		send_frame(frame_length(), -1);
		wait_results_drained();
	endtask

	initial begin
		// shadow state after reset
		blur_cfg = '{kernel_radius: 1, weight_center: 32768, weight_off_one: 0,
			weight_off_two: 0, weight_off_three: 0, norm_reciprocal: 1 << 24,
			frame_width: 640, frame_height: 480};
		foreach (row_ring[r, c])
			row_ring[r][c] = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_tiny_frames();
		test_mid_frame_changes();
		test_widest_rows();
		test_random_frames();
		test_steady_stream();

		wait_results_drained();
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: files.f
src/gbw_pkg.sv
src/gbw_cfg.sv
src/gbw_ctrl.sv
src/gbw_datapath.sv
src/gaussian_blur_window_filter.sv
src/gbw_checker.sv
test/testbench.sv
